### hw/rtl/rmq_pkg.sv
// Shared constants, types and helpers for the rotation matrix to quaternion pipeline.
// Depends on nothing; every module of the block refers to it by scoped names.
package rmq_pkg;

  // Fixed-point format of the datapath
  localparam int FRAC_BITS  = 16;
  localparam int IN_W       = 24;
  localparam int OUT_W      = 18;
  localparam int UNIT_W     = 18;
  localparam int UNIT_ONE   = 1 << FRAC_BITS;

  // Column normalization: L = isqrt(len2 << LEN_SHIFT), u = (c << UNIT_SHIFT) / L
  localparam int LEN_SHIFT  = 14;
  localparam int UNIT_SHIFT = FRAC_BITS + 7;
  localparam int SQ_W       = 2 * IN_W;
  localparam int RAD_W      = SQ_W + LEN_SHIFT;
  localparam int LROOT_W    = RAD_W / 2;
  localparam int QN_W       = FRAC_BITS + 1;
  localparam int NREM_W     = LROOT_W + QN_W;
  localparam int NORM_LAT   = 2 + LROOT_W + QN_W + 1;

  // Triple product and branch selection
  localparam int CROSS_W    = 2 * UNIT_W;
  localparam int CX_W       = UNIT_W + 1;
  localparam int DOT_W      = UNIT_W + CX_W;
  localparam int TR_W       = UNIT_W + 2;
  localparam int A_W        = UNIT_W + 3;
  localparam int NUM_W      = UNIT_W + 1;
  localparam int FRONT_LAT  = 6;

  // Second root and the quaternion dividers
  localparam int RAD2_W     = 36;
  localparam int R_W        = RAD2_W / 2;
  localparam int DEN_W      = R_W + 1;
  localparam int QQ_W       = OUT_W - 1;
  localparam int QREM_W     = DEN_W + QQ_W;
  localparam int QDIV_LAT   = QQ_W + 2;

  localparam int T7_IDX     = NORM_LAT + FRONT_LAT + R_W;
  localparam int PIPE_LAT   = T7_IDX + 1 + QDIV_LAT + 1;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  // Magnitude of a signed input component (most negative value maps to 2^(IN_W-1))
  function automatic logic [IN_W-1:0] mag_in(input logic signed [IN_W-1:0] v);
    logic [IN_W-1:0] neg_v;
    neg_v = IN_W'(-v);
    return v[IN_W-1] ? neg_v : v;
  endfunction

  // True when a unit component lies within [-1.0, +1.0]
  function automatic logic unit_ok(input unit_t v);
    return (v <= UNIT_W'(UNIT_ONE)) && (v >= -UNIT_W'(UNIT_ONE));
  endfunction

endpackage

### hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (Shepperd's method). Takes the three basis columns
// in signed Q7.16 and returns w, x, y, z in signed Q1.16 plus a flag for a zero-length
// column. Fully pipelined: one transaction per cycle unless the output stalls. The column
// root and divide and the quaternion root and divide make up most of the pipeline. A stall
// on the output freezes the whole pipeline. Depends on rmq_pkg, rmq_norm and rmq_qdiv.
module rotation_matrix_to_quaternion (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_col0_x,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_col0_y,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_col0_z,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_col1_x,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_col1_y,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_col1_z,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_col2_x,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_col2_y,
  input  logic signed [rmq_pkg::IN_W-1:0]   in_col2_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rmq_pkg::OUT_W-1:0]  out_quat_w,
  output logic signed [rmq_pkg::OUT_W-1:0]  out_quat_x,
  output logic signed [rmq_pkg::OUT_W-1:0]  out_quat_y,
  output logic signed [rmq_pkg::OUT_W-1:0]  out_quat_z,
  output logic                              out_degenerate
);

  localparam int FB  = rmq_pkg::FRAC_BITS;
  localparam int PL  = rmq_pkg::PIPE_LAT;
  localparam int RTW = rmq_pkg::R_W;
  localparam int QL  = rmq_pkg::QDIV_LAT;
  localparam int NMW = rmq_pkg::NUM_W;
  localparam int OW  = rmq_pkg::OUT_W;

  logic          en;
  logic [PL-1:0] vld_r;

  logic signed [rmq_pkg::IN_W-1:0] col0_v [3];
  logic signed [rmq_pkg::IN_W-1:0] col1_v [3];
  logic signed [rmq_pkg::IN_W-1:0] col2_v [3];
  rmq_pkg::unit_t mu0 [3];
  rmq_pkg::unit_t mu1 [3];
  rmq_pkg::unit_t mu2 [3];
  logic           z0, z1, z2;

  // Advance the whole pipeline unless a finished result is held
  assign en        = ~out_valid | ~out_stall;
  assign in_stall  = ~en;
  assign out_valid = vld_r[PL-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PL-2:0], in_valid};
    end
  end

  // Normalize each column
  assign col0_v[0] = in_col0_x;
  assign col0_v[1] = in_col0_y;
  assign col0_v[2] = in_col0_z;
  assign col1_v[0] = in_col1_x;
  assign col1_v[1] = in_col1_y;
  assign col1_v[2] = in_col1_z;
  assign col2_v[0] = in_col2_x;
  assign col2_v[1] = in_col2_y;
  assign col2_v[2] = in_col2_z;

  rmq_norm u_norm0 (.clk(clk), .en(en), .comp_i(col0_v), .unit_o(mu0), .zero_o(z0));
  rmq_norm u_norm1 (.clk(clk), .en(en), .comp_i(col1_v), .unit_o(mu1), .zero_o(z1));
  rmq_norm u_norm2 (.clk(clk), .en(en), .comp_i(col2_v), .unit_o(mu2), .zero_o(z2));

  // Stage 1: cross product terms of col1 x col2
  rmq_pkg::unit_t m1_r [3][3];
  logic signed [rmq_pkg::CROSS_W-1:0] pa_r [3];
  logic signed [rmq_pkg::CROSS_W-1:0] pb_r [3];
  logic d1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        m1_r[0][e] <= mu0[e];
        m1_r[1][e] <= mu1[e];
        m1_r[2][e] <= mu2[e];
      end
      pa_r[0] <= mu1[1] * mu2[2];
      pb_r[0] <= mu1[2] * mu2[1];
      pa_r[1] <= mu1[2] * mu2[0];
      pb_r[1] <= mu1[0] * mu2[2];
      pa_r[2] <= mu1[0] * mu2[1];
      pb_r[2] <= mu1[1] * mu2[0];
      d1_r    <= z0 | z1 | z2;
    end
  end

  // Stage 2: subtract and scale down, truncating toward zero
  rmq_pkg::unit_t m2_r [3][3];
  logic signed [rmq_pkg::CX_W-1:0] cx_r [3];
  logic d2_r;
  logic signed [rmq_pkg::CROSS_W:0] cdif [3];
  logic signed [rmq_pkg::CROSS_W:0] crnd [3];
  logic signed [rmq_pkg::CROSS_W:0] cadj [3];
  logic signed [rmq_pkg::CROSS_W:0] csh  [3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      cdif[e] = (rmq_pkg::CROSS_W+1)'(pa_r[e]) - (rmq_pkg::CROSS_W+1)'(pb_r[e]);
      crnd[e] = cdif[e][rmq_pkg::CROSS_W] ? (rmq_pkg::CROSS_W+1)'((1 << FB) - 1) : '0;
      cadj[e] = cdif[e] + crnd[e];
      csh[e]  = cadj[e] >>> FB;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_r <= m1_r;
      for (int e = 0; e < 3; e++) begin
        cx_r[e] <= csh[e][rmq_pkg::CX_W-1:0];
      end
      d2_r <= d1_r;
    end
  end

  // Stage 3: dot terms with col0
  rmq_pkg::unit_t m3_r [3][3];
  logic signed [rmq_pkg::DOT_W-1:0] dp_r [3];
  logic d3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m3_r <= m2_r;
      for (int e = 0; e < 3; e++) begin
        dp_r[e] <= m2_r[0][e] * cx_r[e];
      end
      d3_r <= d2_r;
    end
  end

  // Stage 4: negate all columns on a negative triple product
  rmq_pkg::unit_t m4_r [3][3];
  logic d4_r;
  logic signed [rmq_pkg::DOT_W+1:0] dot_sum;

  assign dot_sum = (rmq_pkg::DOT_W+2)'(dp_r[0]) + (rmq_pkg::DOT_W+2)'(dp_r[1])
                 + (rmq_pkg::DOT_W+2)'(dp_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        for (int e = 0; e < 3; e++) begin
          m4_r[c][e] <= dot_sum[rmq_pkg::DOT_W+1] ? -m3_r[c][e] : m3_r[c][e];
        end
      end
      d4_r <= d3_r;
    end
  end

  // Stage 5: trace and pivot axis (lower index wins a tie)
  rmq_pkg::unit_t m5_r [3][3];
  logic signed [rmq_pkg::TR_W-1:0] tr_c;
  logic tpos5_r;
  logic signed [rmq_pkg::TR_W-1:0] tr5_r;
  rmq_pkg::axis_t piv_c, piv5_r;
  rmq_pkg::unit_t dmax;
  logic d5_r;

  always_comb begin
    tr_c = rmq_pkg::TR_W'(m4_r[0][0]) + rmq_pkg::TR_W'(m4_r[1][1])
         + rmq_pkg::TR_W'(m4_r[2][2]);
    piv_c = rmq_pkg::AXIS_X;
    dmax  = m4_r[0][0];
    if (m4_r[1][1] > m4_r[0][0]) begin
      piv_c = rmq_pkg::AXIS_Y;
      dmax  = m4_r[1][1];
    end
    if (m4_r[2][2] > dmax) begin
      piv_c = rmq_pkg::AXIS_Z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m5_r    <= m4_r;
      tr5_r   <= tr_c;
      tpos5_r <= (tr_c > 0);
      piv5_r  <= piv_c;
      d5_r    <= d4_r;
    end
  end

  // Stage 6: radicand and the three divider numerators
  logic signed [rmq_pkg::A_W-1:0] a_c;
  logic signed [NMW-1:0] l_c [3];
  logic [rmq_pkg::RAD2_W-1:0] rad_c;

  function automatic logic signed [rmq_pkg::A_W-1:0] ax(input rmq_pkg::unit_t v);
    return rmq_pkg::A_W'(v);
  endfunction

  function automatic logic signed [NMW-1:0] nx(input rmq_pkg::unit_t v);
    return NMW'(v);
  endfunction

  always_comb begin
    a_c = '0;
    for (int e = 0; e < 3; e++) begin
      l_c[e] = '0;
    end
    if (tpos5_r) begin
      a_c    = rmq_pkg::A_W'(tr5_r) + rmq_pkg::A_W'(rmq_pkg::UNIT_ONE);
      l_c[0] = nx(m5_r[1][2]) - nx(m5_r[2][1]);
      l_c[1] = nx(m5_r[2][0]) - nx(m5_r[0][2]);
      l_c[2] = nx(m5_r[0][1]) - nx(m5_r[1][0]);
    end else begin
      case (piv5_r)
        rmq_pkg::AXIS_X: begin
          a_c    = ax(m5_r[0][0]) - ax(m5_r[1][1]) - ax(m5_r[2][2])
                 + rmq_pkg::A_W'(rmq_pkg::UNIT_ONE);
          l_c[0] = nx(m5_r[0][1]) + nx(m5_r[1][0]);
          l_c[1] = nx(m5_r[0][2]) + nx(m5_r[2][0]);
          l_c[2] = nx(m5_r[1][2]) - nx(m5_r[2][1]);
        end
        rmq_pkg::AXIS_Y: begin
          a_c    = ax(m5_r[1][1]) - ax(m5_r[2][2]) - ax(m5_r[0][0])
                 + rmq_pkg::A_W'(rmq_pkg::UNIT_ONE);
          l_c[0] = nx(m5_r[1][2]) + nx(m5_r[2][1]);
          l_c[1] = nx(m5_r[1][0]) + nx(m5_r[0][1]);
          l_c[2] = nx(m5_r[2][0]) - nx(m5_r[0][2]);
        end
        rmq_pkg::AXIS_Z: begin
          a_c    = ax(m5_r[2][2]) - ax(m5_r[0][0]) - ax(m5_r[1][1])
                 + rmq_pkg::A_W'(rmq_pkg::UNIT_ONE);
          l_c[0] = nx(m5_r[2][0]) + nx(m5_r[0][2]);
          l_c[1] = nx(m5_r[2][1]) + nx(m5_r[1][2]);
          l_c[2] = nx(m5_r[0][1]) - nx(m5_r[1][0]);
        end
        default: begin
          a_c = '0;
        end
      endcase
    end
    // Clamp a negative radicand to zero
    rad_c = a_c[rmq_pkg::A_W-1] ? '0
          : (rmq_pkg::RAD2_W'(a_c[rmq_pkg::A_W-2:0]) << FB);
  end

  // Root pipeline: index 0 is stage 6, one root bit per following stage
  logic [RTW:0]                 s2_rem_r  [0:RTW];
  logic [RTW-1:0]               s2_root_r [0:RTW];
  logic [rmq_pkg::RAD2_W-1:0]   s2_rad_r  [0:RTW];
  logic [2:0][NMW-1:0]          s2_l_r    [0:RTW];
  logic                         s2_t_r    [0:RTW];
  rmq_pkg::axis_t               s2_p_r    [0:RTW];
  logic                         s2_d_r    [0:RTW];

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rem_r[0]  <= '0;
      s2_root_r[0] <= '0;
      s2_rad_r[0]  <= rad_c;
      for (int e = 0; e < 3; e++) begin
        s2_l_r[0][e] <= l_c[e];
      end
      s2_t_r[0] <= tpos5_r;
      s2_p_r[0] <= piv5_r;
      s2_d_r[0] <= d5_r;
    end
  end

  for (genvar s = 0; s < RTW; s++) begin : g_root
    logic [RTW+2:0] cur;
    logic [RTW+2:0] trial;
    logic [RTW+2:0] diff;
    logic           take;

    assign cur   = {s2_rem_r[s], s2_rad_r[s][rmq_pkg::RAD2_W-1 -: 2]};
    assign trial = {1'b0, s2_root_r[s], 2'b01};
    assign diff  = cur - trial;
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        s2_rem_r[s+1]  <= take ? diff[RTW:0] : cur[RTW:0];
        s2_root_r[s+1] <= {s2_root_r[s][RTW-2:0], take};
        s2_rad_r[s+1]  <= {s2_rad_r[s][rmq_pkg::RAD2_W-3:0], 2'b00};
        s2_l_r[s+1]    <= s2_l_r[s];
        s2_t_r[s+1]    <= s2_t_r[s];
        s2_p_r[s+1]    <= s2_p_r[s];
        s2_d_r[s+1]    <= s2_d_r[s];
      end
    end
  end

  // Stage 7: force the root to at least one, form half root and divisor
  logic [RTW-1:0]                 r_c;
  logic [RTW-2:0]                 rh7_r;
  logic [rmq_pkg::DEN_W-1:0]      den7_r;
  logic signed [NMW-1:0]          num7_r [3];
  logic                           t7_r;
  rmq_pkg::axis_t                 p7_r;
  logic                           d7_r;

  assign r_c = (s2_root_r[RTW] == '0) ? RTW'(1) : s2_root_r[RTW];

  always_ff @(posedge clk) begin
    if (en) begin
      rh7_r  <= r_c[RTW-1:1];
      den7_r <= {r_c, 1'b0};
      for (int e = 0; e < 3; e++) begin
        num7_r[e] <= s2_l_r[RTW][e];
      end
      t7_r <= s2_t_r[RTW];
      p7_r <= s2_p_r[RTW];
      d7_r <= s2_d_r[RTW];
    end
  end

  // Divide the three numerators
  logic signed [OW-1:0] qd [3];

  for (genvar e = 0; e < 3; e++) begin : g_qdiv
    rmq_qdiv u_qdiv (
      .clk    (clk),
      .en     (en),
      .num_i  (num7_r[e]),
      .den_i  (den7_r),
      .quot_o (qd[e])
    );
  end

  // Hold the half root and branch choice alongside the dividers
  logic [RTW-2:0]   dl_rh_r [0:QL-1];
  logic             dl_t_r  [0:QL-1];
  rmq_pkg::axis_t   dl_p_r  [0:QL-1];
  logic             dl_d_r  [0:QL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      dl_rh_r[0] <= rh7_r;
      dl_t_r[0]  <= t7_r;
      dl_p_r[0]  <= p7_r;
      dl_d_r[0]  <= d7_r;
      for (int k = 1; k < QL; k++) begin
        dl_rh_r[k] <= dl_rh_r[k-1];
        dl_t_r[k]  <= dl_t_r[k-1];
        dl_p_r[k]  <= dl_p_r[k-1];
        dl_d_r[k]  <= dl_d_r[k-1];
      end
    end
  end

  // Route the half root and quotients to their quaternion parts
  logic signed [OW-1:0] hr;
  assign hr = OW'({1'b0, dl_rh_r[QL-1]});

  always_ff @(posedge clk) begin
    if (en) begin
      out_degenerate <= dl_d_r[QL-1];
      if (dl_t_r[QL-1]) begin
        out_quat_w <= hr;
        out_quat_x <= qd[0];
        out_quat_y <= qd[1];
        out_quat_z <= qd[2];
      end else begin
        case (dl_p_r[QL-1])
          rmq_pkg::AXIS_X: begin
            out_quat_x <= hr;
            out_quat_y <= qd[0];
            out_quat_z <= qd[1];
            out_quat_w <= qd[2];
          end
          rmq_pkg::AXIS_Y: begin
            out_quat_y <= hr;
            out_quat_z <= qd[0];
            out_quat_x <= qd[1];
            out_quat_w <= qd[2];
          end
          rmq_pkg::AXIS_Z: begin
            out_quat_z <= hr;
            out_quat_x <= qd[0];
            out_quat_y <= qd[1];
            out_quat_w <= qd[2];
          end
          default: begin
            out_quat_w <= '0;
            out_quat_x <= '0;
            out_quat_y <= '0;
            out_quat_z <= '0;
          end
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  // Normalized columns never exceed unit magnitude
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[rmq_pkg::NORM_LAT-1] |->
      rmq_pkg::unit_ok(mu0[0]) && rmq_pkg::unit_ok(mu0[1]) && rmq_pkg::unit_ok(mu0[2]) &&
      rmq_pkg::unit_ok(mu1[0]) && rmq_pkg::unit_ok(mu1[1]) && rmq_pkg::unit_ok(mu1[2]) &&
      rmq_pkg::unit_ok(mu2[0]) && rmq_pkg::unit_ok(mu2[1]) && rmq_pkg::unit_ok(mu2[2]))
    else $error("normalized column component outside unit range");

  // Trace branch radicand is above one, so the half root is at least one quarter
  a_trace_root: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[rmq_pkg::T7_IDX] && t7_r |-> rh7_r >= (RTW-1)'(1 << (FB - 2)))
    else $error("trace branch root too small");

  // A held result freezes every valid bit in the pipeline
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(out_valid && out_stall) |-> $stable(vld_r))
    else $error("pipeline moved while output was stalled");
`endif

endmodule

### hw/rtl/rmq_norm.sv
// Column normalizer: squares, bit-per-stage integer root, bit-per-stage divide.
// Depends on rmq_pkg; instantiated once per column by rotation_matrix_to_quaternion.
module rmq_norm (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [rmq_pkg::IN_W-1:0]  comp_i [3],
  output rmq_pkg::unit_t                   unit_o [3],
  output logic                             zero_o
);

  localparam int IW  = rmq_pkg::IN_W;
  localparam int LW  = rmq_pkg::LROOT_W;
  localparam int RW  = rmq_pkg::RAD_W;
  localparam int QW  = rmq_pkg::QN_W;
  localparam int NW  = rmq_pkg::NREM_W;
  localparam int SW  = rmq_pkg::SQ_W;
  localparam int UW  = rmq_pkg::UNIT_W;

  logic [SW-1:0]          sq_r [3];
  logic [2:0][IW-1:0]     ca_r;

  logic [LW:0]            rem_r  [0:LW];
  logic [LW-1:0]          root_r [0:LW];
  logic [RW-1:0]          rad_r  [0:LW];
  logic [2:0][IW-1:0]     sc_r   [0:LW];
  logic                   sz_r   [0:LW];

  logic [2:0][NW-1:0]     dv_rem_r [0:QW-1];
  logic [2:0][QW-1:0]     dv_q_r   [0:QW-1];
  logic [LW-1:0]          dv_l_r   [0:QW-1];
  logic [2:0]             dv_neg_r [0:QW-1];
  logic                   dv_z_r   [0:QW-1];

  rmq_pkg::unit_t         unit_r [3];
  logic                   zero_r;
  logic [SW-1:0]          len2;

  // Square each component
  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        sq_r[e] <= SW'(comp_i[e] * comp_i[e]);
        ca_r[e] <= comp_i[e];
      end
    end
  end

  // Sum the squares and load the root pipeline
  assign len2 = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      rad_r[0]  <= {len2, {rmq_pkg::LEN_SHIFT{1'b0}}};
      sc_r[0]   <= ca_r;
      sz_r[0]   <= (len2 == '0);
    end
  end

  // Resolve one root bit per stage
  for (genvar s = 0; s < LW; s++) begin : g_root
    logic [LW+2:0] cur;
    logic [LW+2:0] trial;
    logic [LW+2:0] diff;
    logic          take;

    assign cur   = {rem_r[s], rad_r[s][RW-1 -: 2]};
    assign trial = {1'b0, root_r[s], 2'b01};
    assign diff  = cur - trial;
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= take ? diff[LW:0] : cur[LW:0];
        root_r[s+1] <= {root_r[s][LW-2:0], take};
        rad_r[s+1]  <= {rad_r[s][RW-3:0], 2'b00};
        sc_r[s+1]   <= sc_r[s];
        sz_r[s+1]   <= sz_r[s];
      end
    end
  end

  // Resolve one quotient bit per stage for all three components
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int B = QW - 1 - j;
    logic [2:0][NW-1:0] src_rem;
    logic [2:0][QW-1:0] src_q;
    logic [LW-1:0]      src_l;
    logic [2:0]         src_neg;
    logic               src_z;
    logic [NW-1:0]      dsh;
    logic [2:0]         take;

    if (j == 0) begin : g_entry
      always_comb begin
        for (int e = 0; e < 3; e++) begin
          src_rem[e] = NW'(rmq_pkg::mag_in(sc_r[LW][e])) << rmq_pkg::UNIT_SHIFT;
          src_neg[e] = sc_r[LW][e][IW-1];
        end
        src_q = '0;
        src_l = root_r[LW];
        src_z = sz_r[LW];
      end
    end else begin : g_chain
      assign src_rem = dv_rem_r[j-1];
      assign src_q   = dv_q_r[j-1];
      assign src_l   = dv_l_r[j-1];
      assign src_neg = dv_neg_r[j-1];
      assign src_z   = dv_z_r[j-1];
    end

    assign dsh = NW'(src_l) << B;

    always_comb begin
      for (int e = 0; e < 3; e++) begin
        take[e] = (src_rem[e] >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int e = 0; e < 3; e++) begin
          dv_rem_r[j][e] <= take[e] ? (src_rem[e] - dsh) : src_rem[e];
          dv_q_r[j][e]   <= {src_q[e][QW-2:0], take[e]};
        end
        dv_l_r[j]   <= src_l;
        dv_neg_r[j] <= src_neg;
        dv_z_r[j]   <= src_z;
      end
    end
  end

  // Apply sign; a zero-length column passes through as zeros
  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        if (dv_z_r[QW-1]) begin
          unit_r[e] <= '0;
        end else if (dv_neg_r[QW-1][e]) begin
          unit_r[e] <= -UW'({1'b0, dv_q_r[QW-1][e]});
        end else begin
          unit_r[e] <= UW'({1'b0, dv_q_r[QW-1][e]});
        end
      end
      zero_r <= dv_z_r[QW-1];
    end
  end

  assign unit_o = unit_r;
  assign zero_o = zero_r;

endmodule

### hw/rtl/rmq_qdiv.sv
// Saturating quotient unit: (num << FRAC_BITS) / den, one quotient bit per stage.
// Depends on rmq_pkg; three instances sit in rotation_matrix_to_quaternion.
module rmq_qdiv (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [rmq_pkg::NUM_W-1:0]    num_i,
  input  logic        [rmq_pkg::DEN_W-1:0]    den_i,
  output logic signed [rmq_pkg::OUT_W-1:0]    quot_o
);

  localparam int QW = rmq_pkg::QQ_W;
  localparam int RW = rmq_pkg::QREM_W;
  localparam int DW = rmq_pkg::DEN_W;
  localparam int NW = rmq_pkg::NUM_W;
  localparam int OW = rmq_pkg::OUT_W;

  logic [RW-1:0]  rem_r [0:QW];
  logic [QW-1:0]  q_r   [0:QW];
  logic [DW-1:0]  den_r [0:QW];
  logic           neg_r [0:QW];
  logic           ovf_r [0:QW];
  logic signed [OW-1:0] quot_r;

  logic [NW-1:0]  num_mag;
  logic [RW-1:0]  num_sh;

  // Take magnitude and flag quotients that cannot fit the output range
  assign num_mag = num_i[NW-1] ? NW'(-num_i) : num_i;
  assign num_sh  = RW'(num_mag) << rmq_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num_sh;
      q_r[0]   <= '0;
      den_r[0] <= den_i;
      neg_r[0] <= num_i[NW-1];
      ovf_r[0] <= (num_sh >= (RW'(den_i) << QW));
    end
  end

  // Restoring divide, most significant quotient bit first
  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int B = QW - j;
    logic [RW-1:0] dsh;
    logic          take;

    assign dsh  = RW'(den_r[j-1]) << B;
    assign take = (rem_r[j-1] >= dsh);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= take ? (rem_r[j-1] - dsh) : rem_r[j-1];
        q_r[j]   <= {q_r[j-1][QW-2:0], take};
        den_r[j] <= den_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  // Restore sign and saturate
  always_ff @(posedge clk) begin
    if (en) begin
      if (ovf_r[QW]) begin
        quot_r <= neg_r[QW] ? rmq_pkg::OUT_MIN : rmq_pkg::OUT_MAX;
      end else if (neg_r[QW]) begin
        quot_r <= -OW'({1'b0, q_r[QW]});
      end else begin
        quot_r <= OW'({1'b0, q_r[QW]});
      end
    end
  end

  assign quot_o = quot_r;

endmodule

### sim/tb.sv
// Testbench for rotation_matrix_to_quaternion: drives column triples and checks quaternions.
// Depends on rmq_pkg and the rotation_matrix_to_quaternion RTL; predicts results itself.
`timescale 1ns / 100ps

module tb;

  localparam int F = rmq_pkg::FRAC_BITS;
  localparam int LAT = rmq_pkg::PIPE_LAT;

  typedef logic signed [rmq_pkg::IN_W-1:0] comp_t;
  typedef logic signed [rmq_pkg::OUT_W-1:0] q_t;

  typedef struct {
    comp_t c[9];
  } matrix_t;

  typedef struct {
    q_t w, x, y, z;
    logic degen;
  } quat_t;

  // directed row: matrix plus an optional typed-in expectation
  typedef struct {
    matrix_t m;
    logic has_exp;
    quat_t q;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  comp_t in_c[9];
  logic out_valid;
  logic out_stall = 1'b0;
  q_t out_quat_w, out_quat_x, out_quat_y, out_quat_z;
  logic out_degenerate;

  quat_t quat_queue[$];
  int err_cnt = 0;
  bit hold_long = 1'b0;
  bit stim_done = 1'b0;

  rotation_matrix_to_quaternion DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_col0_x(in_c[0]), .in_col0_y(in_c[1]), .in_col0_z(in_c[2]),
    .in_col1_x(in_c[3]), .in_col1_y(in_c[4]), .in_col1_z(in_c[5]),
    .in_col2_x(in_c[6]), .in_col2_y(in_c[7]), .in_col2_z(in_c[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
    .out_quat_y(out_quat_y), .out_quat_z(out_quat_z),
    .out_degenerate(out_degenerate)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    foreach (in_c[i]) in_c[i] = '0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic q_t clamp18(longint v);
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return q_t'(v);
  endfunction

  function automatic longint radius(longint a);
    longint r;
    if (a < 0) a = 0;
    r = longint'(int_sqrt(longint'(a) << F));
    return (r == 0) ? 1 : r;
  endfunction

  function automatic longint scaled_half(longint num, longint r);
    return (num * (longint'(1) << F)) / (2 * r);
  endfunction

  // Shepperd conversion of one column triple
  function automatic quat_t shepperd_quat(matrix_t mx);
    longint m[3][3];
    longint q[3];
    longint len2, l, cx, cy, cz, dot, t, r, w;
    int i, j, k;
    quat_t res;
    res.degen = 1'b0;
    for (int c = 0; c < 3; c++) begin
      len2 = 0;
      for (int e = 0; e < 3; e++) begin
        m[c][e] = longint'(mx.c[c*3+e]);
        len2 += m[c][e] * m[c][e];
      end
      if (len2 == 0) begin
        res.degen = 1'b1;
      end else begin
        l = longint'(int_sqrt(longint'(len2) << 14));
        for (int e = 0; e < 3; e++) m[c][e] = (m[c][e] * (longint'(1) << (F + 7))) / l;
      end
    end
    cx = (m[1][1] * m[2][2] - m[1][2] * m[2][1]) / (longint'(1) << F);
    cy = (m[1][2] * m[2][0] - m[1][0] * m[2][2]) / (longint'(1) << F);
    cz = (m[1][0] * m[2][1] - m[1][1] * m[2][0]) / (longint'(1) << F);
    dot = m[0][0] * cx + m[0][1] * cy + m[0][2] * cz;
    if (dot < 0) begin
      for (int c = 0; c < 3; c++)
        for (int e = 0; e < 3; e++) m[c][e] = -m[c][e];
    end
    t = m[0][0] + m[1][1] + m[2][2];
    if (t > 0) begin
      r = radius(t + (longint'(1) << F));
      w = r / 2;
      q[0] = scaled_half(m[1][2] - m[2][1], r);
      q[1] = scaled_half(m[2][0] - m[0][2], r);
      q[2] = scaled_half(m[0][1] - m[1][0], r);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      r = radius(m[i][i] - m[j][j] - m[k][k] + (longint'(1) << F));
      q[i] = r / 2;
      q[j] = scaled_half(m[i][j] + m[j][i], r);
      q[k] = scaled_half(m[i][k] + m[k][i], r);
      w = scaled_half(m[j][k] - m[k][j], r);
    end
    res.w = clamp18(w);
    res.x = clamp18(q[0]);
    res.y = clamp18(q[1]);
    res.z = clamp18(q[2]);
    return res;
  endfunction

  function automatic matrix_t diag_matrix(int a, int b, int c);
    matrix_t mx;
    foreach (mx.c[n]) mx.c[n] = '0;
    mx.c[0] = comp_t'(a);
    mx.c[4] = comp_t'(b);
    mx.c[8] = comp_t'(c);
    return mx;
  endfunction

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'($urandom);
      1: return comp_t'($urandom_range(0, 7) == 0 ? 0 : $urandom_range(0, 4) - 2);
      2: return $urandom_range(0, 1) ? comp_t'(24'h7FFFFF) : comp_t'(24'h800000);
      default: return comp_t'(int'($urandom_range(0, 262144)) - 131072);
    endcase
  endfunction

  // near-rotation (permuted, signed axes with small random noise) or fully random components
  function automatic matrix_t rand_matrix();
    matrix_t mx;
    int perm[3];
    int s, tmp;
    if ($urandom_range(0, 3) == 0) begin
      foreach (mx.c[n]) mx.c[n] = rand_comp();
      if ($urandom_range(0, 5) == 0) begin
        s = $urandom_range(0, 2);
        for (int e = 0; e < 3; e++) mx.c[s*3+e] = '0;
      end
      return mx;
    end
    perm = '{0, 1, 2};
    for (int n = 2; n > 0; n--) begin
      s = $urandom_range(0, n);
      tmp = perm[n]; perm[n] = perm[s]; perm[s] = tmp;
    end
    s = int'($urandom_range(1, 100)) << $urandom_range(8, 16);
    for (int c = 0; c < 3; c++)
      for (int e = 0; e < 3; e++)
        mx.c[c*3+e] = comp_t'((perm[c] == e ? ($urandom_range(0, 1) ? s : -s) : 0)
                              + int'($urandom_range(0, 2 * (s >> 2))) - (s >> 2));
    return mx;
  endfunction

  // put one transaction on the input and hold it until accepted
  task automatic send_matrix(matrix_t mx);
    foreach (in_c[n]) in_c[n] <= mx.c[n];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Stimulus
  initial begin
    row_t rows[$];
    row_t rw;
    matrix_t mx;
    int burst;
    int gap;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // identity and all zeros can be read off directly
    rw.m = diag_matrix(65536, 65536, 65536); rw.has_exp = 1'b1;
    rw.q = '{w: 18'sd65536, x: 0, y: 0, z: 0, degen: 1'b0};
    rows.push_back(rw);
    rw.m = diag_matrix(0, 0, 0); rw.has_exp = 1'b1;
    rw.q = '{w: 0, x: 18'sd32768, y: 0, z: 0, degen: 1'b1};
    rows.push_back(rw);
    rw.has_exp = 1'b0;
    rw.m = diag_matrix(8388607, 8388607, 8388607); rows.push_back(rw);
    rw.m = diag_matrix(-8388608, -8388608, -8388608); rows.push_back(rw);
    rw.m = diag_matrix(65536, -65536, -65536); rows.push_back(rw);
    rw.m = diag_matrix(-65536, 65536, -65536); rows.push_back(rw);
    rw.m = diag_matrix(-65536, -65536, 65536); rows.push_back(rw);
    rw.m = diag_matrix(-65536, -65536, -65536); rows.push_back(rw);
    rw.m = diag_matrix(1, 1, -1); rows.push_back(rw);
    rw.m = diag_matrix(0, 65536, 65536); rows.push_back(rw);
    rw.m = diag_matrix(65536, 0, 65536); rows.push_back(rw);
    rw.m = diag_matrix(65536, 65536, 0); rows.push_back(rw);
    rw.m = diag_matrix(-1, -1, -1); rows.push_back(rw);
    // pivot ties and full-scale inputs
    rw.m = diag_matrix(-65536, -65536, 65536); rw.m.c[1] = 24'sd100; rows.push_back(rw);
    rw.m = diag_matrix(0, 0, 0);
    rw.m.c[1] = 24'sd65536; rw.m.c[3] = 24'sd65536; rw.m.c[8] = -24'sd65536;
    rows.push_back(rw);
    rw.m = diag_matrix(0, 0, 0);
    rw.m.c[2] = 24'sd65536; rw.m.c[3] = 24'sd65536; rw.m.c[7] = 24'sd65536;
    rows.push_back(rw);
    foreach (rw.m.c[n]) rw.m.c[n] = comp_t'(24'h7FFFFF); rows.push_back(rw);
    foreach (rw.m.c[n]) rw.m.c[n] = comp_t'(24'h800000); rows.push_back(rw);
    foreach (rw.m.c[n]) rw.m.c[n] = comp_t'(n % 2 ? 24'h800000 : 24'h7FFFFF);
    rows.push_back(rw);

    foreach (rows[r]) begin
      quat_queue.push_back(rows[r].has_exp ? rows[r].q : shepperd_quat(rows[r].m));
      send_matrix(rows[r].m);
    end
    in_valid <= 1'b0;

    // pause until drained
    wait (quat_queue.size() == 0);
    @(negedge clk);

    // long receiver hold while the sender keeps offering
    hold_long = 1'b1;
    for (int n = 0; n < 1250; n++) begin
      if (n == 300) hold_long = 1'b0;
      mx = rand_matrix();
      quat_queue.push_back(shepperd_quat(mx));
      send_matrix(mx);
      if (burst > 0) begin
        burst--;
      end else begin
        burst = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 12);
        gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stall pattern
  initial begin
    int hold_cnt;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        hold_cnt = 0;
        out_stall <= 1'b1;
        while (hold_cnt < 3 * LAT) begin
          @(negedge clk);
          hold_cnt++;
        end
        out_stall <= 1'b0;
        wait (!hold_long);
      end else begin
        case ($urandom_range(0, 7))
          0, 1: out_stall <= 1'b1;
          2: begin
            out_stall <= 1'b0;
            repeat ($urandom_range(10, 60)) @(negedge clk);
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    quat_t exp_q;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $error("unexpected result transaction");
        err_cnt++;
      end else begin
        exp_q = quat_queue.pop_front();
        if (out_quat_w !== exp_q.w) begin
          $error("quat_w: expected %0d, actual %0d", exp_q.w, out_quat_w); err_cnt++;
        end
        if (out_quat_x !== exp_q.x) begin
          $error("quat_x: expected %0d, actual %0d", exp_q.x, out_quat_x); err_cnt++;
        end
        if (out_quat_y !== exp_q.y) begin
          $error("quat_y: expected %0d, actual %0d", exp_q.y, out_quat_y); err_cnt++;
        end
        if (out_quat_z !== exp_q.z) begin
          $error("quat_z: expected %0d, actual %0d", exp_q.z, out_quat_z); err_cnt++;
        end
        if (out_degenerate !== exp_q.degen) begin
          $error("degenerate: expected %0d, actual %0d", exp_q.degen, out_degenerate);
          err_cnt++;
        end
      end
    end
  end

  // Wind down after the last expected result
  initial begin
    wait (stim_done);
    wait (quat_queue.size() == 0);
    repeat (2 * LAT) @(posedge clk);
    if (err_cnt == 0 && quat_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
